[src/ihex_pkg.sv]
`timescale 1ns / 1ps
package ihex_pkg;

    localparam int LEN_W = 10;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_EOF    = 8'h01;
    localparam logic [7:0] REC_EXT_LO = 8'h02;
    localparam logic [7:0] REC_EXT_HI = 8'h05;

    localparam logic [LEN_W-1:0] MIN_LEN  = LEN_W'(11);
    localparam logic [LEN_W:0]   HEAD_LEN = (LEN_W + 1)'(11);

    typedef enum logic [3:0] {
        ST_STORED     = 4'd0,
        ST_DONE       = 4'd1,
        ST_EXT_IGNORE = 4'd2,
        ST_MALFORMED  = 4'd3,
        ST_LENGTH     = 4'd4,
        ST_DIGIT      = 4'd5,
        ST_CHECKSUM   = 4'd6,
        ST_TYPE       = 4'd7,
        ST_TOO_LONG   = 4'd8,
        ST_NOT_RECORD = 4'd9
    } status_t;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             overflow;
        logic             colon;
        logic             bad_digit;
        logic [3:0]       high_nibble;
        logic [7:0]       count;
        logic             count_bad;
        logic [15:0]      addr;
        logic [7:0]       rec_type;
        logic [7:0]       sum;
    } line_info_t;

    // {valid, nibble}; a bad digit gives nibble f
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] t;
        r = 5'h0F;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            r = {1'b1, t[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            r = {1'b1, t[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage

[src/ihex_stage_mem.sv]
`timescale 1ns / 1ps
module ihex_stage_mem
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [7:0]       wr_data,
    input  logic             re,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ihex_char_dec.sv]
`timescale 1ns / 1ps
module ihex_char_dec
    import ihex_pkg::*;
#(
    parameter int MAX_DATA   = 32,
    parameter int LINE_LIMIT = 550,
    parameter int IDX_W      = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic             clear,
    input  logic [7:0]       ch,
    output line_info_t       info,
    output logic             stage_we,
    output logic [IDX_W-1:0] stage_idx,
    output logic [7:0]       stage_data
);

    localparam logic [LEN_W:0]   LIMIT_EXT = (LEN_W + 1)'(LINE_LIMIT);
    localparam logic [LEN_W-2:0] STAGE_LIM = (LEN_W - 1)'(MAX_DATA);

    line_info_t       info_reg;
    line_info_t       info_next;
    logic [4:0]       digit;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-2:0] k;
    logic [LEN_W-2:0] k_off;
    logic [7:0]       byte_val;

    always_comb
    begin
        info_next  = info_reg;
        digit      = hex_digit(ch);
        pos        = info_reg.len;
        // byte index within the record: count, addr hi, addr lo, type, data
        k          = pos[LEN_W-1:1] - (LEN_W - 1)'(1);
        k_off      = k - (LEN_W - 1)'(4);
        byte_val   = {info_reg.high_nibble, digit[3:0]};
        stage_we   = 1'b0;
        stage_idx  = k_off[IDX_W-1:0];
        stage_data = byte_val;
        if (clear)
        begin
            info_next = '0;
        end
        else if (take)
        begin
            if (({1'b0, pos} + (LEN_W + 1)'(1)) < LIMIT_EXT)
            begin
                info_next.len = pos + LEN_W'(1);
                if (pos == '0)
                begin
                    info_next.colon = (ch == CH_COLON);
                end
                else if (info_reg.colon)
                begin
                    if (!digit[4])
                    begin
                        info_next.bad_digit = 1'b1;
                    end
                    if (pos[0])
                    begin
                        info_next.high_nibble = digit[3:0];
                    end
                    else
                    begin
                        info_next.sum = info_reg.sum + byte_val;
                        priority if (k == '0)
                        begin
                            info_next.count     = byte_val;
                            info_next.count_bad = info_reg.bad_digit | ~digit[4];
                        end
                        else if (k == (LEN_W - 1)'(1))
                        begin
                            info_next.addr[15:8] = byte_val;
                        end
                        else if (k == (LEN_W - 1)'(2))
                        begin
                            info_next.addr[7:0] = byte_val;
                        end
                        else if (k == (LEN_W - 1)'(3))
                        begin
                            info_next.rec_type = byte_val;
                        end
                        else if (k_off < STAGE_LIM)
                        begin
                            stage_we = 1'b1;
                        end
                        else
                        begin
                            stage_we = 1'b0;
                        end
                    end
                end
            end
            else
            begin
                info_next.overflow = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg <= '0;
        end
        else
        begin
            info_reg <= info_next;
        end
    end

    assign info = info_reg;

endmodule

[src/intel_hex_record_loader.sv]
`timescale 1ns / 1ps
// Intel HEX record loader.
// Input channel: one ASCII character per word on char_in (in_valid / in_stall).
// CR or LF ends a line; every other byte is a line character.
// Output channel: words on item_kind .. last_of_run (out_valid / out_stall).
// A valid data record gives one memory write word per data byte, then a status word;
// any other non-empty line gives a single status word with the load counters.
// Throughput: one character per cycle while a line arrives. At a line end the
// input stalls while results drain: the staged bytes sit in a memory with a
// registered read port, so each write word passes a read state and then a
// write state, and the status word follows in the status state; a status-only
// line goes straight from the line end to the status state.
// A stall on the output holds the current word; the output register lets
// the next line's characters be taken while the last status word waits.
// Reset clears the counters, the load state and the line state; the staging
// memory needs no clearing pass.
module intel_hex_record_loader
    import ihex_pkg::*;
#(
    parameter int MAX_DATA   = 32,
    parameter int LINE_LIMIT = 550
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [15:0] write_addr,
    output logic [7:0]  write_data,
    output logic [3:0]  status_code,
    output logic [31:0] loaded_bytes,
    output logic [31:0] loaded_records,
    output logic [31:0] error_total,
    output logic        last_of_run
);

    localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int CNT_W = $clog2(MAX_DATA + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_STATUS = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             load_open_reg, load_open_next;
    logic [31:0]      bytes_reg, bytes_next;
    logic [31:0]      recs_reg, recs_next;
    logic [31:0]      errs_reg, errs_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      base_reg, base_next;
    status_t          code_reg, code_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [15:0]      addr_reg, addr_next;
    logic [7:0]       data_reg, data_next;
    status_t          scode_reg, scode_next;
    logic [31:0]      obytes_reg, obytes_next;
    logic [31:0]      orecs_reg, orecs_next;
    logic [31:0]      oerrs_reg, oerrs_next;
    logic             last_reg, last_next;

    line_info_t       info;
    logic             in_fire;
    logic             line_end;
    logic             slot_free;
    logic             stage_we;
    logic [IDX_W-1:0] stage_idx;
    logic [7:0]       stage_data;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic [CNT_W-1:0] idx_inc;

    logic [31:0]      base_bytes, base_recs, base_errs;
    logic             malformed, len_bad;
    logic [LEN_W:0]   exp_len;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign line_end  = (char_in == CH_CR) || (char_in == CH_LF);
    assign slot_free = !out_valid_reg || !out_stall;
    assign rd_en     = (state_reg == S_READ);
    assign idx_inc   = idx_reg + CNT_W'(1);

    ihex_char_dec #(
        .MAX_DATA   (MAX_DATA),
        .LINE_LIMIT (LINE_LIMIT),
        .IDX_W      (IDX_W)
    ) u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_fire && !line_end),
        .clear      (in_fire && line_end),
        .ch         (char_in),
        .info       (info),
        .stage_we   (stage_we),
        .stage_idx  (stage_idx),
        .stage_data (stage_data)
    );

    ihex_stage_mem #(
        .DEPTH (MAX_DATA),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .we      (stage_we),
        .wr_idx  (stage_idx),
        .wr_data (stage_data),
        .re      (rd_en),
        .rd_idx  (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // record checks, in priority order
    always_comb
    begin
        base_bytes = load_open_reg ? bytes_reg : 32'd0;
        base_recs  = load_open_reg ? recs_reg  : 32'd0;
        base_errs  = load_open_reg ? errs_reg  : 32'd0;
        malformed  = (info.len < MIN_LEN) || !info.len[0];
        exp_len    = {2'b00, info.count, 1'b0} + HEAD_LEN;
        len_bad    = info.count_bad || (info.count > 8'(MAX_DATA))
                     || ({1'b0, info.len} != exp_len);
    end

    always_comb
    begin
        state_next     = state_reg;
        load_open_next = load_open_reg;
        bytes_next     = bytes_reg;
        recs_next      = recs_reg;
        errs_next      = errs_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        code_next      = code_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        scode_next     = scode_reg;
        obytes_next    = obytes_reg;
        orecs_next     = orecs_reg;
        oerrs_next     = oerrs_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && line_end)
                begin
                    priority if (info.overflow)
                    begin
                        errs_next  = errs_reg + 32'd1;
                        code_next  = ST_TOO_LONG;
                        state_next = S_STATUS;
                    end
                    else if (info.len == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (info.colon)
                    begin
                        load_open_next = 1'b1;
                        bytes_next     = base_bytes;
                        recs_next      = base_recs;
                        errs_next      = base_errs;
                        state_next     = S_STATUS;
                        priority if (malformed)
                        begin
                            errs_next = base_errs + 32'd1;
                            code_next = ST_MALFORMED;
                        end
                        else if (len_bad)
                        begin
                            errs_next = base_errs + 32'd1;
                            code_next = ST_LENGTH;
                        end
                        else if (info.bad_digit)
                        begin
                            errs_next = base_errs + 32'd1;
                            code_next = ST_DIGIT;
                        end
                        else if (info.sum != 8'h00)
                        begin
                            errs_next = base_errs + 32'd1;
                            code_next = ST_CHECKSUM;
                        end
                        else if (info.rec_type == REC_DATA)
                        begin
                            bytes_next = base_bytes + 32'(info.count);
                            recs_next  = base_recs + 32'd1;
                            code_next  = ST_STORED;
                            idx_next   = '0;
                            cnt_next   = info.count[CNT_W-1:0];
                            base_next  = info.addr;
                            if (info.count != 8'h00)
                            begin
                                state_next = S_READ;
                            end
                        end
                        else if (info.rec_type == REC_EOF)
                        begin
                            load_open_next = 1'b0;
                            code_next      = ST_DONE;
                        end
                        else if (info.rec_type >= REC_EXT_LO && info.rec_type <= REC_EXT_HI)
                        begin
                            code_next = ST_EXT_IGNORE;
                        end
                        else
                        begin
                            errs_next = base_errs + 32'd1;
                            code_next = ST_TYPE;
                        end
                    end
                    else
                    begin
                        code_next  = ST_NOT_RECORD;
                        state_next = S_STATUS;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_WRITE;
                    addr_next      = base_reg + 16'(idx_reg);
                    data_next      = rd_data;
                    scode_next     = ST_STORED;
                    obytes_next    = 32'd0;
                    orecs_next     = 32'd0;
                    oerrs_next     = 32'd0;
                    last_next      = 1'b0;
                    idx_next       = idx_inc;
                    state_next     = (idx_inc == cnt_reg) ? S_STATUS : S_READ;
                end
            end

            S_STATUS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STATUS;
                    addr_next      = 16'd0;
                    data_next      = 8'd0;
                    scode_next     = code_reg;
                    obytes_next    = bytes_reg;
                    orecs_next     = recs_reg;
                    oerrs_next     = errs_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_open_reg <= 1'b0;
            bytes_reg     <= 32'd0;
            recs_reg      <= 32'd0;
            errs_reg      <= 32'd0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_open_reg <= load_open_next;
            bytes_reg     <= bytes_next;
            recs_reg      <= recs_next;
            errs_reg      <= errs_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the output word and emit context
    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        code_reg   <= code_next;
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        scode_reg  <= scode_next;
        obytes_reg <= obytes_next;
        orecs_reg  <= orecs_next;
        oerrs_reg  <= oerrs_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign item_kind      = kind_reg;
    assign write_addr     = addr_reg;
    assign write_data     = data_reg;
    assign status_code    = scode_reg;
    assign loaded_bytes   = obytes_reg;
    assign loaded_records = orecs_reg;
    assign error_total    = oerrs_reg;
    assign last_of_run    = last_reg;

endmodule

[verif/intel_hex_record_loader_tb.sv]
`timescale 1ns / 1ps
module intel_hex_record_loader_tb;
    import ihex_pkg::*;

    localparam int MAX_DATA   = 32;
    localparam int LINE_LIMIT = 550;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [7:0]  data;
        status_t     code;
        logic [31:0] nbytes;
        logic [31:0] nrecords;
        logic [31:0] nerrors;
        logic        last;
    } loader_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic        item_kind;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [3:0]  status_code;
    logic [31:0] loaded_bytes;
    logic [31:0] loaded_records;
    logic [31:0] error_total;
    logic        last_of_run;

    // shared between stimulus, receiver and checker
    bit          gaps_on       = 1'b1;
    bit          stalls_on     = 1'b1;
    int          receiver_hold = 0;
    int          fail_count    = 0;
    int          chars_sent    = 0;
    int          lines_sent    = 0;

    // decoder prediction state
    logic        load_open_p;
    logic [31:0] byte_total_p;
    logic [31:0] record_total_p;
    logic [31:0] error_total_p;
    int unsigned line_len_p;
    logic        overflow_p;
    logic        colon_p;
    logic        bad_digit_p;
    logic        count_bad_p;
    logic [3:0]  nibble_p;
    logic [7:0]  count_p;
    logic [7:0]  type_p;
    logic [7:0]  sum_p;
    logic [15:0] addr_p;
    logic [7:0]  stage_p [MAX_DATA];

    loader_word_t expected_words[$];

    intel_hex_record_loader #(
        .MAX_DATA   (MAX_DATA),
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .write_addr     (write_addr),
        .write_data     (write_data),
        .status_code    (status_code),
        .loaded_bytes   (loaded_bytes),
        .loaded_records (loaded_records),
        .error_total    (error_total),
        .last_of_run    (last_of_run)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // {valid, nibble}; anything that is not hex reads as nibble f
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, c[3:0]};
        if (folded >= 8'h61 && folded <= 8'h66)
            return {1'b1, folded[3:0] + 4'd9};
        return 5'h0F;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        logic [4:0] d;
        c = any_char();
        d = digit_of(c);
        while (d[4])
        begin
            c = any_char();
            d = digit_of(c);
        end
        return c;
    endfunction

    function automatic logic [7:0] eol();
        return $urandom_range(0, 1) ? CH_CR : CH_LF;
    endfunction

    task automatic clear_line_p();
        line_len_p  = 0;
        overflow_p  = 1'b0;
        colon_p     = 1'b0;
        bad_digit_p = 1'b0;
        count_bad_p = 1'b0;
        nibble_p    = 4'h0;
        count_p     = 8'h00;
        type_p      = 8'h00;
        sum_p       = 8'h00;
        addr_p      = 16'h0000;
    endtask

    task automatic push_status(input status_t code);
        loader_word_t w;
        w          = '0;
        w.kind     = KIND_STATUS;
        w.code     = code;
        w.nbytes   = byte_total_p;
        w.nrecords = record_total_p;
        w.nerrors  = error_total_p;
        w.last     = 1'b1;
        expected_words.push_back(w);
    endtask

    task automatic close_record();
        loader_word_t w;
        // first record of a load clears the counters before any check
        if (!load_open_p)
        begin
            byte_total_p   = '0;
            record_total_p = '0;
            error_total_p  = '0;
            load_open_p    = 1'b1;
        end
        if (line_len_p < 11 || line_len_p % 2 == 0)
        begin
            error_total_p++;
            push_status(ST_MALFORMED);
        end
        else if (count_bad_p || count_p > MAX_DATA || line_len_p != 2 * count_p + 11)
        begin
            error_total_p++;
            push_status(ST_LENGTH);
        end
        else if (bad_digit_p)
        begin
            error_total_p++;
            push_status(ST_DIGIT);
        end
        else if (sum_p != 8'h00)
        begin
            error_total_p++;
            push_status(ST_CHECKSUM);
        end
        else if (type_p == REC_DATA)
        begin
            for (int i = 0; i < count_p; i++)
            begin
                w      = '0;
                w.kind = KIND_WRITE;
                w.addr = addr_p + 16'(i);
                w.data = stage_p[i];
                expected_words.push_back(w);
            end
            byte_total_p += count_p;
            record_total_p++;
            push_status(ST_STORED);
        end
        else if (type_p == REC_EOF)
        begin
            load_open_p = 1'b0;
            push_status(ST_DONE);
        end
        else if (type_p >= REC_EXT_LO && type_p <= REC_EXT_HI)
            push_status(ST_EXT_IGNORE);
        else
        begin
            error_total_p++;
            push_status(ST_TYPE);
        end
    endtask

    task automatic take_line_char(input logic [7:0] c);
        int unsigned pos;
        int unsigned k;
        logic [4:0]  dig;
        logic [7:0]  b;
        pos        = line_len_p;
        line_len_p = pos + 1;
        if (pos == 0)
            colon_p = (c == CH_COLON);
        else if (colon_p)
        begin
            dig = digit_of(c);
            if (!dig[4])
                bad_digit_p = 1'b1;
            if (pos % 2 == 1)
                nibble_p = dig[3:0];
            else
            begin
                k     = (pos - 2) / 2;
                b     = {nibble_p, dig[3:0]};
                sum_p = sum_p + b;
                case (k)
                    0:
                    begin
                        count_p     = b;
                        count_bad_p = bad_digit_p;
                    end
                    1: addr_p[15:8] = b;
                    2: addr_p[7:0]  = b;
                    3: type_p       = b;
                    default:
                        if (k - 4 < MAX_DATA)
                            stage_p[k - 4] = b;
                endcase
            end
        end
    endtask

    task automatic predict_char(input logic [7:0] c);
        if (c == CH_CR || c == CH_LF)
        begin
            if (overflow_p)
            begin
                error_total_p++;
                push_status(ST_TOO_LONG);
            end
            else if (line_len_p != 0)
            begin
                if (colon_p)
                    close_record();
                else
                    push_status(ST_NOT_RECORD);
            end
            clear_line_p();
        end
        else if (line_len_p + 1 < LINE_LIMIT)
            take_line_char(c);
        else
            overflow_p = 1'b1;
    endtask

    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(eol());
    endtask

    task automatic send_plain_line(input int n, input logic [7:0] first);
        send_char(first);
        for (int i = 1; i < n; i++)
            send_char(any_char());
        send_char(eol());
    endtask

    // bad_at >= 0 puts a non-hex character at that digit position
    task automatic send_record(input logic [7:0] rtype, input logic [15:0] addr,
                               input int count_field, input int n_data,
                               input logic [7:0] twist, input int bad_at);
        logic [7:0] bytes_q[$];
        logic [7:0] text_q[$];
        logic [7:0] sum;
        bit         lower;
        lower = 1'($urandom_range(0, 1));
        bytes_q.push_back(8'(count_field));
        bytes_q.push_back(addr[15:8]);
        bytes_q.push_back(addr[7:0]);
        bytes_q.push_back(rtype);
        for (int i = 0; i < n_data; i++)
            bytes_q.push_back(8'($urandom_range(0, 255)));
        sum = 8'h00;
        foreach (bytes_q[i])
            sum = sum + bytes_q[i];
        bytes_q.push_back(8'h00 - sum + twist);
        text_q.push_back(CH_COLON);
        foreach (bytes_q[i])
        begin
            text_q.push_back(hex_char(bytes_q[i][7:4], lower));
            text_q.push_back(hex_char(bytes_q[i][3:0], lower));
        end
        if (bad_at >= 0 && bad_at + 1 < text_q.size())
            text_q[bad_at + 1] = junk_char();
        foreach (text_q[i])
            send_char(text_q[i]);
        send_char(eol());
    endtask

    // sender goes idle until every expected word has come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_line();
        int          pick;
        int          n;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_DATA) : $urandom_range(0, 8);
        addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                           : 16'($urandom);
        if (pick < 60)
            send_record(REC_DATA, addr, n, n, 8'h00, -1);
        else if (pick < 66)
            send_record(REC_EOF, addr, 0, 0, 8'h00, -1);
        else if (pick < 72)
            send_record(8'($urandom_range(REC_EXT_LO, REC_EXT_HI)), addr, n, n, 8'h00, -1);
        else if (pick < 76)
            send_record(8'($urandom_range(6, 255)), addr, n, n, 8'h00, -1);
        else if (pick < 81)
            send_record(REC_DATA, addr, n, n, 8'($urandom_range(1, 255)), -1);
        else if (pick < 85)
            send_record(REC_DATA, addr, n, n, 8'h00, $urandom_range(0, 2 * n + 9));
        else if (pick < 89)
            send_record(REC_DATA, addr, n + 1, n, 8'h00, -1);
        else if (pick < 92)
        begin
            n = MAX_DATA + 1 + $urandom_range(0, 3);
            send_record(REC_DATA, addr, n, n, 8'h00, -1);
        end
        else if (pick < 94)
            send_char(eol());
        else
            send_plain_line($urandom_range(1, 20),
                            $urandom_range(0, 1) ? CH_COLON : any_char());
        lines_sent++;
    endtask

    task automatic test_good_records();
        send_char(CH_CR);
        send_char(CH_LF);
        send_record(REC_DATA, 16'h0000, 1, 1, 8'h00, -1);
        send_record(REC_DATA, 16'h1234, 0, 0, 8'h00, -1);
        // full stage, address wraps past ffff
        send_record(REC_DATA, 16'hFFF0, MAX_DATA, MAX_DATA, 8'h00, -1);
        send_record(REC_EXT_LO, 16'h0000, 2, 2, 8'h00, -1);
        send_record(8'h04, 16'h0000, 2, 2, 8'h00, -1);
        send_record(REC_EXT_HI, 16'h0000, 4, 4, 8'h00, -1);
        send_record(8'h06, 16'h0100, 1, 1, 8'h00, -1);
        send_record(8'hFF, 16'h0100, 0, 0, 8'h00, -1);
        send_record(REC_EOF, 16'h0000, 0, 0, 8'h00, -1);
        // new load starts with cleared counters
        send_record(REC_DATA, 16'hFFFF, 3, 3, 8'h00, -1);
    endtask

    task automatic test_bad_records();
        send_text(":00000001F");
        send_text(":00000001FF0");
        send_record(REC_DATA, 16'h2000, 4, 3, 8'h00, -1);
        send_record(REC_DATA, 16'h2000, MAX_DATA + 1, MAX_DATA + 1, 8'h00, -1);
        send_record(REC_DATA, 16'h2000, 2, 2, 8'h00, 0);
        send_record(REC_DATA, 16'h2000, 2, 2, 8'h00, 9);
        send_record(REC_DATA, 16'h2000, 2, 2, 8'h01, -1);
        send_char(8'h00);
        send_char(eol());
        send_char(8'hFF);
        send_char(eol());
        send_text("load 1234");
        send_record(REC_EOF, 16'h0000, 0, 0, 8'h00, -1);
    endtask

    task automatic test_line_limit();
        send_plain_line(LINE_LIMIT - 1, 8'h41);
        send_plain_line(LINE_LIMIT, 8'h41);
        send_plain_line(LINE_LIMIT - 1, CH_COLON);
        send_plain_line(LINE_LIMIT + 5, CH_COLON);
    endtask

    task automatic test_random_lines();
        while (chars_sent < 150 || lines_sent < 40)
        begin
            send_random_line();
            if ($urandom_range(0, 9) == 0)
                wait_drain();
        end
    endtask

    task automatic test_steady_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (12)
            send_random_line();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_back_pressure();
        wait_drain();
        gaps_on       = 1'b0;
        receiver_hold = 300;
        // output held off while full records keep coming, so the input stalls
        repeat (4)
            send_record(REC_DATA, 16'($urandom), MAX_DATA, MAX_DATA, 8'h00, -1);
        send_record(REC_EOF, 16'h0000, 0, 0, 8'h00, -1);
        wait_drain();
        gaps_on = 1'b1;
        repeat (6)
            send_random_line();
        wait_drain();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 50)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_word();
        loader_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word", {31'd0, item_kind}, 32'd0);
            return;
        end
        want = expected_words.pop_front();
        if (item_kind != want.kind)
            report_mismatch("item_kind", 32'(item_kind), 32'(want.kind));
        if (write_addr != want.addr)
            report_mismatch("write_addr", 32'(write_addr), 32'(want.addr));
        if (write_data != want.data)
            report_mismatch("write_data", 32'(write_data), 32'(want.data));
        if (status_code != want.code)
            report_mismatch("status_code", 32'(status_code), 32'(want.code));
        if (loaded_bytes != want.nbytes)
            report_mismatch("loaded_bytes", loaded_bytes, want.nbytes);
        if (loaded_records != want.nrecords)
            report_mismatch("loaded_records", loaded_records, want.nrecords);
        if (error_total != want.nerrors)
            report_mismatch("error_total", error_total, want.nerrors);
        if (last_of_run != want.last)
            report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_word();
    end

    // receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold > 0)
            begin
                out_stall <= 1'b1;
                receiver_hold--;
            end
            else
                out_stall <= stalls_on && ($urandom_range(0, 99) < 8);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL intel_hex_record_loader");
        $finish;
    end

    initial
    begin
        in_valid       = 1'b0;
        char_in        = 8'h00;
        rst_n          = 1'b0;
        load_open_p    = 1'b0;
        byte_total_p   = '0;
        record_total_p = '0;
        error_total_p  = '0;
        clear_line_p();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_good_records();
        test_bad_records();
        test_line_limit();
        test_random_lines();
        test_steady_stream();
        test_back_pressure();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drain();
        repeat (10)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS intel_hex_record_loader");
        else
            $display("FAIL intel_hex_record_loader");
        $finish;
    end

endmodule
